@@ sv/sdg_pkg.sv @@
// ----------------------------------------------------------------------------
// sdg_pkg: shared types and constants of the sidechain ducker gain block
// Field widths, register index codes, multiplier request and the 2^-x table.
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_RATIO     = 3'd1,
    CFG_RANGE     = 3'd2,
    CFG_ATTACK    = 3'd3,
    CFG_RELEASE   = 3'd4,
    CFG_HOLD      = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'hEE00;  // -18 dB
  localparam logic [7:0]  RATIO_RST     = 8'd48;
  localparam logic [14:0] RANGE_RST     = 15'd6144;
  localparam logic [15:0] COEF_RST      = 16'hFFFF;
  localparam logic [19:0] HOLD_RST      = 20'd0;

  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd197283;
  localparam logic [31:0] LOG2_PER_DB_Q24 = 32'd2786625;
  localparam logic [16:0] LOG_FLOOR_MAG   = 17'd32768;

  // operands for the shared multiplier
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef logic [30:0] pow_tab_t [16];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry k is 2^(-2^-(k+1)) in Q1.30, by repeated truncated square roots of 0.5
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      t = isqrt64(t << 30);
      tab[k] = t[30:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

@@ sv/sdg_if.sv @@
// ----------------------------------------------------------------------------
// sdg_if: valid/ready channels of the sidechain ducker gain block
// Sample input, gain result and register write channels.
// ----------------------------------------------------------------------------
interface sdg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface sdg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;
  logic [14:0] reduction;
  modport source (output valid, gain, reduction, input ready);
  modport sink   (input valid, gain, reduction, output ready);
endinterface

interface sdg_cfg_if
  import sdg_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/sdg_mul.sv @@
// ----------------------------------------------------------------------------
// sdg_mul: shared 32x32 unsigned multiplier
// Product is registered; valid in the cycle after the operands.
// ----------------------------------------------------------------------------
module sdg_mul
  import sdg_pkg::*;
(
  input  logic        clk_i,
  input  mul_req_t    req_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;

endmodule

@@ sv/sidechain_ducker_gain.sv @@
// ----------------------------------------------------------------------------
// sidechain_ducker_gain: RMS ducking gain computer with hold, attack, release
// Sums sample squares per chunk, then runs level, hold, smoothing and gain.
// ----------------------------------------------------------------------------
// A sample that does not end a chunk is squared, then accumulated. A chunk-ending
// sample then also runs the bit-serial divide, the normalize shift and the two
// 16-round loops through the one multiplier before the next sample is taken.
// Reset (async, active low) clears the sequencer, accumulators, hold and
// smoothing state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module sidechain_ducker_gain
  import sdg_pkg::*;
#(
  parameter int unsigned MAX_CHUNK = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sdg_in_if.sink   in_i,
  sdg_out_if.source out_o,
  sdg_cfg_if.sink  cfg_i
);

  localparam int unsigned CntW    = $clog2(MAX_CHUNK + 1);
  localparam int unsigned SumW    = 31 + CntW;
  localparam int unsigned DivCntW = $clog2(SumW);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD, ST_DIV, ST_CLAMP, ST_NORM, ST_SQ_MUL, ST_SQ_UPD,
    ST_MAG_MUL, ST_LEVEL, ST_TGT_MUL, ST_TGT, ST_SM_MUL, ST_SM,
    ST_EXP_MUL, ST_EXP, ST_POW_MUL, ST_POW_UPD, ST_FIN
  } state_e;

  // configuration registers
  logic [15:0] thr_q;
  logic [7:0]  ratio_q;
  logic [14:0] range_q;
  logic [15:0] att_q, rel_q;
  logic [19:0] hold_len_q;

  // sequencer and datapath
  state_e              state_q;
  logic                last_q;
  logic [SumW-1:0]     sum_q;     // square sum, then quotient during divide
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     rem_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [30:0]         x_q;       // normalized mantissa, later pow product
  logic [4:0]          e_q;
  logic [15:0]         frac_q;
  logic                zero_q;
  logic [3:0]          it_q;
  logic [20:0]         hold_rem_q;
  logic [15:0]         held_q;
  logic [15:0]         ovs_q;
  logic                act_q;
  logic [14:0]         target_q;
  logic [15:0]         red_q;
  logic [5:0]          ip_q;
  logic [15:0]         gain_q;
  logic [14:0]         red_out_q;
  logic                out_valid_q;

  mul_req_t    mul_req;
  logic [63:0] prod;

  sdg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // --- combinational helpers -------------------------------------------------
  logic [16:0]       abs_s;
  logic [CntW-1:0]   cnt_inc;
  logic              chunk_end;
  logic [CntW:0]     rem_sh;
  logic              div_ge;
  logic [20:0]       mag;
  logic [24:0]       mag_rnd;
  logic [16:0]       mag_cl;
  logic signed [16:0] level;
  logic signed [16:0] thr_ext;
  logic [16:0]       ovs_full;
  logic [31:0]       xs;
  logic [15:0]       tgt16;
  logic              sm_up, sm_ge;
  logic [15:0]       sm_coef, sm_diff;
  logic [16:0]       sm_step;
  logic [19:0]       tgt_raw;
  logic [21:0]       exp_v;
  logic [30:0]       pow_rnd;
  logic [5:0]        gsh;
  logic [32:0]       gsum;
  logic [32:0]       gshift;
  logic [15:0]       gain_val;
  logic              out_free;

  assign abs_s     = in_i.sample[15] ? (17'd0 - {in_i.sample[15], in_i.sample})
                                     : {1'b0, in_i.sample};
  assign cnt_inc   = cnt_q + CntW'(1);
  assign chunk_end = last_q || (cnt_inc == CntW'(MAX_CHUNK));

  assign rem_sh = {rem_q, sum_q[SumW-1]};
  assign div_ge = rem_sh >= {1'b0, cnt_q};

  assign mag     = {5'd30, 16'd0} - {e_q, frac_q};
  assign mag_rnd = 25'(({24'd0, prod[39:0]} + 64'd8388608) >> 24);
  assign mag_cl  = (mag_rnd > 25'(LOG_FLOOR_MAG)) ? LOG_FLOOR_MAG : mag_rnd[16:0];
  assign level   = zero_q ? -$signed(LOG_FLOOR_MAG) : -$signed(mag_cl);
  assign thr_ext = $signed({thr_q[15], thr_q});
  assign ovs_full = 17'(level - thr_ext);

  assign xs = prod[61:30];

  assign tgt16   = {1'b0, target_q};
  assign sm_up   = tgt16 > red_q;
  assign sm_ge   = tgt16 >= red_q;
  assign sm_coef = sm_up ? att_q : rel_q;
  assign sm_diff = sm_ge ? (tgt16 - red_q) : (red_q - tgt16);
  assign sm_step = 17'((prod[32:0] + 33'd32768) >> 16);

  assign tgt_raw = prod[23:4];
  assign exp_v   = 22'((prod[37:0] + 38'd32768) >> 16);
  assign pow_rnd = 31'((prod[60:0] + 61'd536870912) >> 30);

  // gain = round(m / 2^(15 + ip)); zero once the shift passes 31
  assign gsh      = 6'd15 + ip_q;
  assign gsum     = {2'b0, x_q} + (33'd1 << (gsh - 6'd1));
  assign gshift   = gsum >> gsh;
  assign gain_val = (ip_q > 6'd16) ? 16'd0 : gshift[15:0];

  assign out_free = !out_valid_q || out_o.ready;

  // multiplier operand select
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_IDLE:    mul_req = '{a: 32'(abs_s), b: 32'(abs_s)};
      ST_SQ_MUL:  mul_req = '{a: 32'(x_q), b: 32'(x_q)};
      ST_MAG_MUL: mul_req = '{a: 32'(mag), b: DB_PER_LOG2_Q16};
      ST_TGT_MUL: mul_req = '{a: 32'(ovs_q), b: 32'(ratio_q)};
      ST_SM_MUL:  mul_req = '{a: 32'(sm_coef), b: 32'(sm_diff)};
      ST_EXP_MUL: mul_req = '{a: 32'(red_q), b: LOG2_PER_DB_Q24};
      ST_POW_MUL: mul_req = '{a: 32'(x_q), b: 32'(POW_TAB[it_q])};
      default:    mul_req = '0;
    endcase
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.gain      = gain_q;
  assign out_o.reduction = red_out_q;

  // --- configuration registers -----------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESHOLD_RST;
      ratio_q    <= RATIO_RST;
      range_q    <= RANGE_RST;
      att_q      <= COEF_RST;
      rel_q      <= COEF_RST;
      hold_len_q <= HOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_THRESHOLD: thr_q      <= cfg_i.data[15:0];
        CFG_RATIO:     ratio_q    <= cfg_i.data[7:0];
        CFG_RANGE:     range_q    <= cfg_i.data[14:0];
        CFG_ATTACK:    att_q      <= cfg_i.data[15:0];
        CFG_RELEASE:   rel_q      <= cfg_i.data[15:0];
        CFG_HOLD:      hold_len_q <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  // --- sequencer -------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      x_q         <= '0;
      e_q         <= '0;
      frac_q      <= '0;
      zero_q      <= 1'b0;
      it_q        <= '0;
      hold_rem_q  <= '0;
      held_q      <= '0;
      ovs_q       <= '0;
      act_q       <= 1'b0;
      target_q    <= '0;
      red_q       <= '0;
      ip_q        <= '0;
      gain_q      <= '0;
      red_out_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the final step reloads the result register itself
      if (out_valid_q && out_o.ready && state_q != ST_FIN) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            last_q  <= in_i.last;
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          sum_q <= sum_q + {(SumW-31)'(0), prod[30:0]};
          cnt_q <= cnt_inc;
          if (chunk_end) begin
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem_q     <= div_ge ? CntW'(rem_sh - {1'b0, cnt_q}) : rem_sh[CntW-1:0];
          sum_q     <= {sum_q[SumW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(SumW - 1)) state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          x_q     <= (sum_q > SumW'(64'd1 << 30)) ? 31'h40000000 : sum_q[30:0];
          zero_q  <= (sum_q == '0);
          sum_q   <= '0;
          e_q     <= 5'd30;
          frac_q  <= '0;
          it_q    <= '0;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (zero_q) begin
            state_q <= ST_LEVEL;
          end else if (x_q[30]) begin
            state_q <= ST_SQ_MUL;
          end else begin
            x_q <= {x_q[29:0], 1'b0};
            e_q <= e_q - 5'd1;
          end
        end
        ST_SQ_MUL: state_q <= ST_SQ_UPD;
        ST_SQ_UPD: begin
          // log2 fraction bit: square, renormalize on overflow
          if (xs[31]) begin
            x_q    <= xs[31:1];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            x_q    <= xs[30:0];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          it_q    <= it_q + 4'd1;
          state_q <= (it_q == 4'd15) ? ST_MAG_MUL : ST_SQ_MUL;
        end
        ST_MAG_MUL: state_q <= ST_LEVEL;
        ST_LEVEL: begin
          cnt_q <= '0;
          if (level > thr_ext) begin
            ovs_q      <= ovs_full[15:0];
            held_q     <= ovs_full[15:0];
            hold_rem_q <= {1'b0, hold_len_q};
            act_q      <= 1'b1;
          end else if (hold_rem_q != '0) begin
            ovs_q <= held_q;
            if (hold_rem_q > 21'(cnt_q)) begin
              hold_rem_q <= hold_rem_q - 21'(cnt_q);
              act_q      <= 1'b1;
            end else begin
              hold_rem_q <= '0;
              act_q      <= 1'b0;
            end
          end else begin
            act_q <= 1'b0;
          end
          state_q <= ST_TGT_MUL;
        end
        ST_TGT_MUL: state_q <= ST_TGT;
        ST_TGT: begin
          if (!act_q) target_q <= '0;
          else if (tgt_raw > 20'(range_q)) target_q <= range_q;
          else target_q <= tgt_raw[14:0];
          state_q <= ST_SM_MUL;
        end
        ST_SM_MUL: state_q <= ST_SM;
        ST_SM: begin
          red_q   <= sm_ge ? (red_q + sm_step[15:0]) : (red_q - sm_step[15:0]);
          state_q <= ST_EXP_MUL;
        end
        ST_EXP_MUL: state_q <= ST_EXP;
        ST_EXP: begin
          ip_q    <= exp_v[21:16];
          frac_q  <= exp_v[15:0];
          x_q     <= 31'h40000000;
          it_q    <= '0;
          state_q <= ST_POW_MUL;
        end
        ST_POW_MUL: state_q <= ST_POW_UPD;
        ST_POW_UPD: begin
          if (frac_q[4'd15 - it_q]) x_q <= pow_rnd;
          it_q    <= it_q + 4'd1;
          state_q <= (it_q == 4'd15) ? ST_FIN : ST_POW_MUL;
        end
        ST_FIN: begin
          if (out_free) begin
            gain_q      <= gain_val;
            red_out_q   <= red_q[14:0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result appeared outside the final step");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_CHUNK))
    else $error("chunk count past its limit");

  a_red_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q[15] == 1'b0)
    else $error("smoothed reduction left the 15-bit range");

  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP) |=> sum_q == '0)
    else $error("square sum not cleared after the divide");
`endif

endmodule
